// ===== rtl/rtb_pkg.sv =====
// package for the reload timer bank: action codes, status codes and the
// command and mask structs passed between the core and its timer cells
// no dependencies
package rtb_pkg;

    localparam int MASK_BITS = 8;

    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_BAD_ARG = 1'b1;

    localparam logic [15:0] MAX_RELOAD_RST = 16'hFFFF;

    // command broadcast to every cell for one transaction
    typedef struct packed {
        logic       valid;
        logic [1:0] action;
        logic [2:0] index;
        logic       set_ok;
        logic       rep;
    } rtb_cmd_t;

    // masks handed from cell to cell along the chain
    typedef struct packed {
        logic [MASK_BITS-1:0] expired;
        logic [MASK_BITS-1:0] active;
    } rtb_mask_t;

endpackage

// ===== rtl/rtb_cell.sv =====
// one countdown timer of the bank: count, reload value, repeat and active flags
// takes the broadcast command and adds its own bits to the mask chain
// depends on rtb_pkg
module rtb_cell #(
    parameter int INDEX      = 0,
    parameter int COUNT_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rtb_pkg::rtb_cmd_t       cmd,
    input  logic [COUNT_BITS-1:0]   reload,
    input  rtb_pkg::rtb_mask_t      mask_in,
    output rtb_pkg::rtb_mask_t      mask_out
);
    import rtb_pkg::*;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] reload_reg;
    logic [COUNT_BITS-1:0] reload_next;
    logic                  rep_reg;
    logic                  rep_next;
    logic                  active_reg;
    logic                  active_next;
    logic                  hit;
    logic                  expired;

    generate
        if (INDEX < MASK_BITS) begin : g_addr
            assign hit = (cmd.index == 3'(INDEX));
        end
        else begin : g_noaddr
            assign hit = 1'b0;
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        reload_next = reload_reg;
        rep_next    = rep_reg;
        active_next = active_reg;
        expired     = 1'b0;
        if (cmd.valid)
        begin
            unique case (cmd.action)
                ACT_SET:
                begin
                    if (cmd.set_ok && hit)
                    begin
                        reload_next = reload;
                        rep_next    = cmd.rep;
                    end
                end
                ACT_START:
                begin
                    if (hit)
                    begin
                        count_next  = reload_reg;
                        active_next = 1'b1;
                    end
                end
                ACT_STOP:
                begin
                    if (hit)
                    begin
                        active_next = 1'b0;
                    end
                end
                default:
                begin
                    if (active_reg)
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            expired = 1'b1;
                            if (rep_reg)
                            begin
                                count_next = reload_reg;
                            end
                            else
                            begin
                                active_next = 1'b0;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // only the first eight timers are visible in the masks
    generate
        if (INDEX < MASK_BITS) begin : g_vis
            always_comb
            begin
                mask_out = mask_in;
                mask_out.expired[INDEX] = mask_in.expired[INDEX] | expired;
                mask_out.active[INDEX]  = mask_in.active[INDEX] | active_next;
            end
        end
        else begin : g_hid
            assign mask_out = mask_in;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            reload_reg <= '0;
            rep_reg    <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            reload_reg <= reload_next;
            rep_reg    <= rep_next;
            active_reg <= active_next;
        end
    end

endmodule

// ===== rtl/reload_timer_bank_core.sv =====
// reload timer bank: a chain of timer cells driven by one command per transaction
// depends on rtb_pkg and rtb_cell
//
// usage:
//   command channel: drive action, timer_index, reload_ticks and repeat_req
//   with start high; the transaction is taken at a rising edge where start is
//   high and busy is low. busy stays low, so a command may follow every cycle.
//   result channel: in the cycle after each command, done pulses for one cycle
//   with status, expired_mask and active_mask. the receiver cannot stall, so
//   a result not taken in that cycle is gone.
//   throughput is 1 command per cycle: every cell updates
//   its count in the same cycle and the masks ripple along the cell chain
//   into the result register.
//   configuration: APB write of max_reload at byte address 0 (pwdata[15:0]);
//   pready is always high, reads return the current value.
//   reset: all timers stopped with zero count, reload and repeat flag;
//   max_reload returns to 65535 and no result is pending.
module reload_timer_bank_core #(
    parameter int TIMER_COUNT = 8,
    parameter int COUNT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [2:0]  timer_index,
    input  logic [15:0] reload_ticks,
    input  logic        repeat_req,
    output logic        done,
    output logic        status,
    output logic [7:0]  expired_mask,
    output logic [7:0]  active_mask,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rtb_pkg::*;

    logic [15:0]           max_reload_reg;
    logic                  done_reg;
    logic                  status_reg;
    logic [MASK_BITS-1:0]  expired_reg;
    logic [MASK_BITS-1:0]  active_reg;
    rtb_cmd_t              cmd;
    logic [COUNT_BITS-1:0] reload_c;
    rtb_mask_t             chain [TIMER_COUNT+1];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, max_reload_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reload_reg <= MAX_RELOAD_RST;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            max_reload_reg <= pwdata[15:0];
        end
    end

    assign cmd.valid  = start && !busy;
    assign cmd.action = action;
    assign cmd.index  = timer_index;
    assign cmd.set_ok = (reload_ticks <= max_reload_reg);
    assign cmd.rep    = repeat_req;
    assign reload_c   = COUNT_BITS'(reload_ticks);

    assign chain[0] = '0;

    generate
        for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_cell
            rtb_cell #(
                .INDEX      (i),
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .reload   (reload_c),
                .mask_in  (chain[i]),
                .mask_out (chain[i+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            status_reg  <= ST_OK;
            expired_reg <= '0;
            active_reg  <= '0;
        end
        else
        begin
            done_reg <= cmd.valid;
            if (cmd.valid)
            begin
                status_reg  <= (action == ACT_SET && !cmd.set_ok) ? ST_BAD_ARG : ST_OK;
                expired_reg <= chain[TIMER_COUNT].expired;
                active_reg  <= chain[TIMER_COUNT].active;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign expired_mask = expired_reg;
    assign active_mask  = active_reg;

endmodule

// ===== rtl/rtb_checker.sv =====
// port-level checks for the reload timer bank core, attached by bind
// depends on rtb_pkg and reload_timer_bank_core
module rtb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] action,
    input logic       done,
    input logic       status,
    input logic [7:0] expired_mask,
    input logic [7:0] active_mask
);
    import rtb_pkg::*;

    // every taken transaction answers in the next cycle
    a_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("missing result after command");

    // no result without a command
    a_no_spur: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without command");

    // only a tick can report expiries
    a_exp_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action != ACT_TICK) |=> (expired_mask == 8'd0))
        else $error("expiry on non-tick command");

    // a set never starts or stops a timer
    a_set_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_SET) |=> (active_mask == $past(active_mask)))
        else $error("set changed active timers");

    // only a set can fail
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action != ACT_SET) |=> (status == ST_OK))
        else $error("bad status outside set");

endmodule

bind reload_timer_bank_core rtb_checker u_rtb_checker (.*);
